### rtl/aspt_pkg.sv
package aspt_pkg;

    // Coordinate format: signed two's complement, 4 fraction bits.
    localparam int CW    = 16;                  // coordinate width
    localparam int RW    = CW - 1;              // radius width
    localparam int DW    = CW + 1;              // width of a coordinate difference
    localparam int PW    = 2 * DW;              // width of one signed difference product
    localparam int DTW   = 2 * DW + 1;          // width of a sum of three products
    localparam int LW    = 2 * DW;              // squared axis length
    localparam int MW    = 2 * DW;              // magnitude of one cross product component
    localparam int CRW   = 2 * MW + 2;          // squared cross product length
    localparam int RRW   = 2 * RW;              // radius squared
    localparam int RCW   = RRW + LW;            // cylinder right-hand side
    localparam int SW    = LW + RW;             // cone scaled radius term
    localparam int CLO   = CRW / 2;             // low slice of the cross product sum
    localparam int CHI   = CRW - CLO;
    localparam int SLO   = SW / 2;              // low slice of the cone radius term
    localparam int SHI   = SW - SLO;
    localparam int LHW   = CRW + LW;            // cone left-hand side
    localparam int RHW   = 2 * SW;              // cone right-hand side

    localparam int NSTG  = 8;                   // register stages, output stage included

    localparam int IN_TW  = ((3 * CW + 7) / 8) * 8;
    localparam int OUT_TW = 8;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = CW;

    localparam logic [CFG_IW-1:0] CFG_KIND   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_BASE_X = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_BASE_Y = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BASE_Z = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_END_X  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_END_Y  = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_END_Z  = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_RADIUS = 3'd7;

    localparam logic SHAPE_CYLINDER = 1'b0;
    localparam logic SHAPE_CONE     = 1'b1;

endpackage

### rtl/axial_solid_point_test.sv
// Point-in-solid test for a right circular cylinder or cone.
//
// Configuration: a plain write port. When i_cfg_we is high at a rising edge, register
// i_cfg_idx takes i_cfg_wdata: 0 shape (0 cylinder, 1 cone), 1..3 base centre x/y/z,
// 4..6 end point x/y/z (top centre or apex), 7 radius. Write only while the block is idle.
//
// Input stream: each request carries one query point on s_axis. Output stream: one result
// per request on m_axis, in request order, telling whether the point lies strictly
// inside the solid, and whether the axis has zero length (then it is never inside).
//
// The test runs through eight register stages: differences, products, sums, squares,
// wide partial products and a final compare. One request can enter every cycle while
// the result stream is not stalled, so the sustained rate is one point per clock; the
// widest stage is a pair of 35 by 34 bit partial products of the cone comparison.
//
// Each stage holds while the stage after it is full and stalled, so a receiver stall
// closes up empty stages first; s_axis tready drops only once all eight stages hold a
// request. Synchronous reset clears all configuration registers to zero and discards
// every request in flight.
module axial_solid_point_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [aspt_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [aspt_pkg::CFG_DW-1:0]   i_cfg_wdata,
    // Request stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [aspt_pkg::IN_TW-1:0]    i_s_axis_tdata,  // point_x, point_y, point_z
    // Result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [aspt_pkg::OUT_TW-1:0]   o_m_axis_tdata   // inside_res, axis_zero, zeros
);
    import aspt_pkg::*;

    // Configuration registers.
    logic                  r_kind;
    logic signed [CW-1:0]  r_base [3];
    logic signed [CW-1:0]  r_end  [3];
    logic [RW-1:0]         r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= SHAPE_CYLINDER;
            r_radius <= '0;
            for (int i = 0; i < 3; i++) begin
                r_base[i] <= '0;
                r_end[i]  <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KIND:   r_kind      <= i_cfg_wdata[0];
                CFG_BASE_X: r_base[0]   <= i_cfg_wdata;
                CFG_BASE_Y: r_base[1]   <= i_cfg_wdata;
                CFG_BASE_Z: r_base[2]   <= i_cfg_wdata;
                CFG_END_X:  r_end[0]    <= i_cfg_wdata;
                CFG_END_Y:  r_end[1]    <= i_cfg_wdata;
                CFG_END_Z:  r_end[2]    <= i_cfg_wdata;
                CFG_RADIUS: r_radius    <= i_cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or the stage after it moves on.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_en[0];

    // Incoming point fields.
    logic signed [CW-1:0] w_pt [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pt[i] = $signed(i_s_axis_tdata[i*CW +: CW]);
        end
    end

    // Stage 1: point and axis relative to the base centre.
    logic signed [DW-1:0] r1_p [3];
    logic signed [DW-1:0] r1_a [3];
    logic                 r1_kind;
    logic [RW-1:0]        r1_r;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i] <= DW'(w_pt[i]) - DW'(r_base[i]);
                r1_a[i] <= DW'(r_end[i]) - DW'(r_base[i]);
            end
            r1_kind <= r_kind;
            r1_r    <= r_radius;
        end
    end

    // Stage 2: axis squares, dot product terms, cross product terms and radius squared.
    logic signed [PW-1:0] r2_sq [3];
    logic signed [PW-1:0] r2_dp [3];
    logic signed [PW-1:0] r2_cp [3];
    logic signed [PW-1:0] r2_cn [3];
    logic [RRW-1:0]       r2_rr;
    logic [RW-1:0]        r2_r;
    logic                 r2_kind;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= r1_a[i] * r1_a[i];
                r2_dp[i] <= r1_p[i] * r1_a[i];
                // Cross product component i is p[i+1]*a[i+2] - p[i+2]*a[i+1].
                r2_cp[i] <= r1_p[(i+1)%3] * r1_a[(i+2)%3];
                r2_cn[i] <= r1_p[(i+2)%3] * r1_a[(i+1)%3];
            end
            r2_rr   <= r1_r * r1_r;
            r2_r    <= r1_r;
            r2_kind <= r1_kind;
        end
    end

    // Stage 3: axis length squared, dot product and cross product magnitudes.
    logic signed [DTW-1:0] w3_len2;
    logic signed [DTW-1:0] w3_cd  [3];
    logic signed [DTW-1:0] w3_cdn [3];

    always_comb begin
        w3_len2 = DTW'(r2_sq[0]) + DTW'(r2_sq[1]) + DTW'(r2_sq[2]);
        for (int i = 0; i < 3; i++) begin
            w3_cd[i]  = DTW'(r2_cp[i]) - DTW'(r2_cn[i]);
            w3_cdn[i] = DTW'(r2_cn[i]) - DTW'(r2_cp[i]);
        end
    end

    logic [LW-1:0]         r3_len2;
    logic signed [DTW-1:0] r3_dot;
    logic [MW-1:0]         r3_cm [3];
    logic [RRW-1:0]        r3_rr;
    logic [RW-1:0]         r3_r;
    logic                  r3_kind;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_len2 <= w3_len2[LW-1:0];
            r3_dot  <= DTW'(r2_dp[0]) + DTW'(r2_dp[1]) + DTW'(r2_dp[2]);
            for (int i = 0; i < 3; i++) begin
                r3_cm[i] <= w3_cd[i][DTW-1] ? w3_cdn[i][MW-1:0] : w3_cd[i][MW-1:0];
            end
            r3_rr   <= r2_rr;
            r3_r    <= r2_r;
            r3_kind <= r2_kind;
        end
    end

    // Stage 4: range checks on t, squares of the cross components, cylinder bound.
    logic           r4_zero;
    logic           r4_oor;
    logic [2*MW-1:0] r4_sq [3];
    logic [RCW-1:0] r4_rcyl;
    logic [LW-1:0]  r4_d;
    logic [LW-1:0]  r4_len2;
    logic [RW-1:0]  r4_r;
    logic           r4_kind;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_zero <= (r3_len2 == '0);
            // Outside unless 0 < dot < len2.
            r4_oor  <= r3_dot[DTW-1] || (r3_dot == '0)
                       || (r3_dot >= $signed({1'b0, r3_len2}));
            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= r3_cm[i] * r3_cm[i];
            end
            r4_rcyl <= r3_rr * r3_len2;
            r4_d    <= r3_len2 - r3_dot[LW-1:0];
            r4_len2 <= r3_len2;
            r4_r    <= r3_r;
            r4_kind <= r3_kind;
        end
    end

    // Stage 5: squared cross product length and the cone's scaled radius term.
    logic [CRW-1:0] r5_cr2;
    logic [SW-1:0]  r5_s;
    logic [LW-1:0]  r5_len2;
    logic [RCW-1:0] r5_rcyl;
    logic           r5_zero;
    logic           r5_oor;
    logic           r5_kind;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_cr2  <= CRW'(r4_sq[0]) + CRW'(r4_sq[1]) + CRW'(r4_sq[2]);
            r5_s    <= r4_d * r4_r;
            r5_len2 <= r4_len2;
            r5_rcyl <= r4_rcyl;
            r5_zero <= r4_zero;
            r5_oor  <= r4_oor;
            r5_kind <= r4_kind;
        end
    end

    // Stage 6: partial products of the cone comparison, cylinder compare.
    logic [CLO+LW-1:0]   r6_lh;
    logic [CHI+LW-1:0]   r6_hh;
    logic [2*SLO-1:0]    r6_sll;
    logic [SLO+SHI-1:0]  r6_slh;
    logic [2*SHI-1:0]    r6_shh;
    logic                r6_cyl;
    logic                r6_zero;
    logic                r6_oor;
    logic                r6_kind;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_lh   <= r5_cr2[CLO-1:0] * r5_len2;
            r6_hh   <= r5_cr2[CRW-1:CLO] * r5_len2;
            r6_sll  <= r5_s[SLO-1:0] * r5_s[SLO-1:0];
            r6_slh  <= r5_s[SLO-1:0] * r5_s[SW-1:SLO];
            r6_shh  <= r5_s[SW-1:SLO] * r5_s[SW-1:SLO];
            r6_cyl  <= (r5_cr2 < CRW'(r5_rcyl));
            r6_zero <= r5_zero;
            r6_oor  <= r5_oor;
            r6_kind <= r5_kind;
        end
    end

    // Stage 7: assemble both sides of the cone comparison.
    logic [LHW-1:0] r7_lhs;
    logic [RHW-1:0] r7_rhs;
    logic           r7_cyl;
    logic           r7_zero;
    logic           r7_oor;
    logic           r7_kind;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_lhs  <= (LHW'(r6_hh) << CLO) + LHW'(r6_lh);
            // The middle term appears twice in the square, hence the extra shift.
            r7_rhs  <= (RHW'(r6_shh) << (2 * SLO)) + (RHW'(r6_slh) << (SLO + 1))
                       + RHW'(r6_sll);
            r7_cyl  <= r6_cyl;
            r7_zero <= r6_zero;
            r7_oor  <= r6_oor;
            r7_kind <= r6_kind;
        end
    end

    // Stage 8: output register.
    logic r8_in;
    logic r8_az;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r8_in <= !r7_zero && !r7_oor
                     && ((r7_kind == SHAPE_CONE) ? (r7_lhs < LHW'(r7_rhs)) : r7_cyl);
            r8_az <= r7_zero;
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {{(OUT_TW-2){1'b0}}, r8_az, r8_in};

`ifndef ASSERT_OFF
    // A degenerate axis must never report a point inside.
    a_zero_axis_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[1]) |-> !o_m_axis_tdata[0])
        else $error("inside reported with a zero-length axis");

    // Input backpressure only once every stage holds a request.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_vld == {NSTG{1'b1}}))
        else $error("request stream stalled with an empty stage");

    // A request leaving the last inner stage lands in the output register.
    a_last_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en[NSTG-1] && r_vld[NSTG-2]) |=> o_m_axis_tvalid)
        else $error("request lost between the last two stages");
`endif

endmodule
